// ----- design/spkc_pkg.sv -----
// Shared types, constants and helper functions for the SRAM PUF key conditioner.
package spkc_pkg;

    localparam int BYTE_W    = 8;
    localparam int CRC_W     = 16;
    localparam int COUNT_W   = 11;
    localparam int ONES_W    = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CRC_W-1:0]   CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0]   CRC_POLY  = 16'h1021;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_HISTORY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASKED_SEED   = 1'd1;

    // One classified item passed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] sram_byte;
        logic [BYTE_W-1:0] mask_byte;
        logic [BYTE_W-1:0] stable_byte;
        logic [ONES_W-1:0] raw_ones;
        logic [ONES_W-1:0] saved_ones;
        logic [ONES_W-1:0] mask_ones;
        logic [ONES_W-1:0] stable_ones;
        logic              last_byte;
        logic              clear;
    } spkc_item_t;

    function automatic logic [ONES_W-1:0] ones8(input logic [BYTE_W-1:0] v);
        logic [ONES_W-1:0] n;
        n = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            n = n + ONES_W'(v[i]);
        end
        return n;
    endfunction

    // CRC-16/CCITT-FALSE, MSB first, one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] total,
                                                   input logic [ONES_W-1:0] n);
        logic [COUNT_W:0] s;
        s = {1'b0, total} + (COUNT_W+1)'(n);
        return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
    endfunction

endpackage

// ----- design/spkc_if.sv -----
// Channel interfaces: input bytes and result items.
interface spkc_in_if
    import spkc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] sram_byte;
    logic [BYTE_W-1:0] saved_key_byte;
    logic [BYTE_W-1:0] saved_mask_byte;
    logic              last_byte;

    modport source (output valid, sram_byte, saved_key_byte, saved_mask_byte, last_byte,
                    input ready);
    modport sink   (input valid, sram_byte, saved_key_byte, saved_mask_byte, last_byte,
                    output ready);
endinterface

interface spkc_out_if
    import spkc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  new_key_byte;
    logic [BYTE_W-1:0]  new_mask_byte;
    logic [BYTE_W-1:0]  stable_key_byte;
    logic               block_done;
    logic [CRC_W-1:0]   seed;
    logic [COUNT_W-1:0] raw_ones;
    logic [COUNT_W-1:0] saved_ones;
    logic [COUNT_W-1:0] mask_ones;
    logic [COUNT_W-1:0] stable_ones;

    modport source (output valid, new_key_byte, new_mask_byte, stable_key_byte, block_done,
                    seed, raw_ones, saved_ones, mask_ones, stable_ones,
                    input ready);
    modport sink   (input valid, new_key_byte, new_mask_byte, stable_key_byte, block_done,
                    seed, raw_ones, saved_ones, mask_ones, stable_ones,
                    output ready);
endinterface

// ----- design/spkc_front.sv -----
// Front end: accepts input bytes, builds mask and stable byte, counts bits.
module spkc_front
    import spkc_pkg::*;
(
    spkc_in_if.sink    sram,
    input  logic       clear_history,
    input  logic       q_ready,
    output logic       q_push,
    output spkc_item_t q_item
);

    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] stable;

    // New mask is the saved mask plus the bits that differ from the saved key
    assign mask   = sram.saved_mask_byte | (sram.sram_byte ^ sram.saved_key_byte);
    assign stable = sram.sram_byte & ~mask;

    assign sram.ready = q_ready;
    assign q_push     = sram.valid && q_ready;

    always_comb
    begin
        q_item.sram_byte   = sram.sram_byte;
        q_item.mask_byte   = mask;
        q_item.stable_byte = stable;
        q_item.raw_ones    = ones8(sram.sram_byte);
        q_item.saved_ones  = ones8(sram.saved_key_byte);
        q_item.mask_ones   = ones8(mask);
        q_item.stable_ones = ones8(stable);
        q_item.last_byte   = sram.last_byte;
        q_item.clear       = clear_history;
    end

endmodule

// ----- design/spkc_queue.sv -----
// Two-entry queue between front and back.
module spkc_queue
    import spkc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  spkc_item_t push_item,
    output logic       push_ready,
    input  logic       pop,
    output logic       pop_valid,
    output spkc_item_t pop_item
);

    spkc_item_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- design/spkc_back.sv -----
// Back end: running totals, the two CRCs and the result register.
module spkc_back
    import spkc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        masked_seed,
    input  logic        q_valid,
    input  spkc_item_t  q_item,
    output logic        q_pop,
    spkc_out_if.source  result
);

    logic [CRC_W-1:0]   crc_raw_reg;
    logic [CRC_W-1:0]   crc_stable_reg;
    logic [COUNT_W-1:0] count_raw_reg;
    logic [COUNT_W-1:0] count_saved_reg;
    logic [COUNT_W-1:0] count_mask_reg;
    logic [COUNT_W-1:0] count_stable_reg;
    logic               out_valid_reg;

    logic [CRC_W-1:0]   crc_raw_next;
    logic [CRC_W-1:0]   crc_stable_next;
    logic [COUNT_W-1:0] count_raw_next;
    logic [COUNT_W-1:0] count_saved_next;
    logic [COUNT_W-1:0] count_mask_next;
    logic [COUNT_W-1:0] count_stable_next;
    logic [CRC_W-1:0]   seed_next;

    logic [BYTE_W-1:0]  key_reg;
    logic [BYTE_W-1:0]  mask_reg;
    logic [BYTE_W-1:0]  stable_reg;
    logic               done_reg;
    logic [CRC_W-1:0]   seed_reg;
    logic [COUNT_W-1:0] raw_ones_reg;
    logic [COUNT_W-1:0] saved_ones_reg;
    logic [COUNT_W-1:0] mask_ones_reg;
    logic [COUNT_W-1:0] stable_ones_reg;

    // Take an item when the result register is free or being emptied
    assign q_pop = q_valid && (!out_valid_reg || result.ready);

    // Updated totals and CRCs including this byte
    always_comb
    begin
        crc_raw_next      = crc_byte(crc_raw_reg, q_item.sram_byte);
        crc_stable_next   = crc_byte(crc_stable_reg, q_item.stable_byte);
        count_raw_next    = sat_add(count_raw_reg, q_item.raw_ones);
        count_saved_next  = sat_add(count_saved_reg, q_item.saved_ones);
        count_mask_next   = sat_add(count_mask_reg, q_item.mask_ones);
        count_stable_next = sat_add(count_stable_reg, q_item.stable_ones);
        seed_next         = '0;
        if (q_item.last_byte && !q_item.clear)
            seed_next = masked_seed ? crc_stable_next : crc_raw_next;
    end

    // Block state, re-armed after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_raw_reg      <= CRC_INIT;
            crc_stable_reg   <= CRC_INIT;
            count_raw_reg    <= '0;
            count_saved_reg  <= '0;
            count_mask_reg   <= '0;
            count_stable_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                if (q_item.last_byte)
                begin
                    crc_raw_reg      <= CRC_INIT;
                    crc_stable_reg   <= CRC_INIT;
                    count_raw_reg    <= '0;
                    count_saved_reg  <= '0;
                    count_mask_reg   <= '0;
                    count_stable_reg <= '0;
                end
                else
                begin
                    crc_raw_reg      <= crc_raw_next;
                    crc_stable_reg   <= crc_stable_next;
                    count_raw_reg    <= count_raw_next;
                    count_saved_reg  <= count_saved_next;
                    count_mask_reg   <= count_mask_next;
                    count_stable_reg <= count_stable_next;
                end
            end
            if (q_pop)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            key_reg         <= q_item.sram_byte;
            mask_reg        <= q_item.clear ? '0 : q_item.mask_byte;
            stable_reg      <= q_item.clear ? '0 : q_item.stable_byte;
            done_reg        <= q_item.last_byte;
            seed_reg        <= seed_next;
            raw_ones_reg    <= count_raw_next;
            saved_ones_reg  <= count_saved_next;
            mask_ones_reg   <= count_mask_next;
            stable_ones_reg <= count_stable_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.new_key_byte    = key_reg;
    assign result.new_mask_byte   = mask_reg;
    assign result.stable_key_byte = stable_reg;
    assign result.block_done      = done_reg;
    assign result.seed            = seed_reg;
    assign result.raw_ones        = raw_ones_reg;
    assign result.saved_ones      = saved_ones_reg;
    assign result.mask_ones       = mask_ones_reg;
    assign result.stable_ones     = stable_ones_reg;

endmodule

// ----- design/sram_puf_key_conditioner_unit.sv -----
// Top level of the SRAM PUF key conditioner: config registers, front, queue, back.
//
//  Port      | Dir  | Item
//  ----------+------+--------------------------------------------------------
//  sram      | in   | raw byte, saved key byte, saved mask byte, last flag
//  result    | out  | key/mask/stable bytes, done flag, seed, four bit totals
//  cfg_*     | in   | write-only registers: clear_history, masked_seed
//
// One byte per cycle sustained while results are taken; the CRC and popcount update
// of the back end is combinational, so an accepted byte passes the queue storage
// and then the result register before its result is valid.
// Reset returns both CRCs to 0xFFFF, the totals and control registers to zero; no
// clearing pass is needed. A stalled result holds in the output register while
// the two-entry queue keeps taking bytes until it is full.
module sram_puf_key_conditioner_unit
    import spkc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    spkc_in_if.sink               sram,
    spkc_out_if.source            result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic       clear_history_reg;
    logic       masked_seed_reg;
    logic       q_ready;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    spkc_item_t push_item;
    spkc_item_t pop_item;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_history_reg <= 1'b0;
            masked_seed_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLEAR_HISTORY: clear_history_reg <= cfg_data[0];
                CFG_MASKED_SEED:   masked_seed_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    spkc_front u_front (
        .sram          (sram),
        .clear_history (clear_history_reg),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    spkc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (pop_item)
    );

    spkc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .masked_seed (masked_seed_reg),
        .q_valid     (q_valid),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .result      (result)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the SRAM PUF key conditioner unit.
module testbench;
    import spkc_pkg::*;

    localparam logic [CRC_W-1:0]   CRC_START        = 16'hFFFF;
    localparam logic [CRC_W-1:0]   CCITT_POLY       = 16'h1021;
    localparam int                 TOTAL_CEIL       = 2047;
    localparam int                 WATCHDOG_LIMIT   = 4000;
    localparam int                 LONG_HOLD_AT     = 100;
    localparam int                 LONG_HOLD_CYCLES = 400;
    localparam int                 MAX_PRINTS       = 40;
    localparam int                 SAT_BLOCK_LEN    = 262;

    // One input item: raw byte plus what was saved last power-up
    typedef struct packed {
        logic [BYTE_W-1:0] sram_byte;
        logic [BYTE_W-1:0] saved_key_byte;
        logic [BYTE_W-1:0] saved_mask_byte;
        logic              last_byte;
    } puf_byte_t;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0]  new_key_byte;
        logic [BYTE_W-1:0]  new_mask_byte;
        logic [BYTE_W-1:0]  stable_key_byte;
        logic               block_done;
        logic [CRC_W-1:0]   seed;
        logic [COUNT_W-1:0] raw_ones;
        logic [COUNT_W-1:0] saved_ones;
        logic [COUNT_W-1:0] mask_ones;
        logic [COUNT_W-1:0] stable_ones;
    } conditioned_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Drive-side variables feeding the channels
    puf_byte_t offer       = '0;
    logic      offer_valid = 1'b0;
    logic      take_result = 1'b0;

    spkc_in_if  sram_ch();
    spkc_out_if res_ch();

    assign sram_ch.valid           = offer_valid;
    assign sram_ch.sram_byte       = offer.sram_byte;
    assign sram_ch.saved_key_byte  = offer.saved_key_byte;
    assign sram_ch.saved_mask_byte = offer.saved_mask_byte;
    assign sram_ch.last_byte       = offer.last_byte;
    assign res_ch.ready            = take_result;

    sram_puf_key_conditioner_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sram      (sram_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the configuration registers
    logic clear_mode       = 1'b0;
    logic seed_from_stable = 1'b0;

    // Running block state of the predictor
    logic [CRC_W-1:0]   crc_raw_run    = CRC_START;
    logic [CRC_W-1:0]   crc_stable_run = CRC_START;
    logic [COUNT_W-1:0] raw_total      = '0;
    logic [COUNT_W-1:0] saved_total    = '0;
    logic [COUNT_W-1:0] mask_total     = '0;
    logic [COUNT_W-1:0] stable_total   = '0;

    puf_byte_t    pending_sram[$];
    conditioned_t predicted_results[$];

    int  bytes_offered  = 0;
    int  bytes_accepted = 0;
    int  results_seen   = 0;
    int  mismatch_count = 0;
    int  items_queued   = 0;
    int  idle_pct       = 0;
    int  gap_left       = 0;
    int  hold_left      = 0;
    logic long_hold_done = 1'b0;
    int  quiet_cycles   = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // CRC-16/CCITT-FALSE, fed one bit at a time, MSB first
    function automatic logic [CRC_W-1:0] crc16_ccitt(logic [CRC_W-1:0] acc,
                                                     logic [BYTE_W-1:0] d);
        logic fb;
        for (int k = BYTE_W - 1; k >= 0; k--)
        begin
            fb  = acc[CRC_W-1] ^ d[k];
            acc = {acc[CRC_W-2:0], 1'b0};
            if (fb)
                acc = acc ^ CCITT_POLY;
        end
        return acc;
    endfunction

    function automatic logic [COUNT_W-1:0] add_sat(logic [COUNT_W-1:0] total, int n);
        int s;
        s = int'(total) + n;
        return (s > TOTAL_CEIL) ? COUNT_W'(TOTAL_CEIL) : COUNT_W'(s);
    endfunction

    // Works out the result item for one accepted byte and advances the block state
    function automatic conditioned_t condition_byte(puf_byte_t it);
        conditioned_t     r;
        logic [BYTE_W-1:0] mask;
        logic [BYTE_W-1:0] stable;
        mask   = it.saved_mask_byte | (it.sram_byte ^ it.saved_key_byte);
        stable = it.sram_byte & ~mask;

        raw_total      = add_sat(raw_total, $countones(it.sram_byte));
        saved_total    = add_sat(saved_total, $countones(it.saved_key_byte));
        mask_total     = add_sat(mask_total, $countones(mask));
        stable_total   = add_sat(stable_total, $countones(stable));
        crc_raw_run    = crc16_ccitt(crc_raw_run, it.sram_byte);
        crc_stable_run = crc16_ccitt(crc_stable_run, stable);

        r.new_key_byte    = it.sram_byte;
        r.new_mask_byte   = clear_mode ? '0 : mask;
        r.stable_key_byte = clear_mode ? '0 : stable;
        r.block_done      = it.last_byte;
        r.seed            = '0;
        if (it.last_byte && !clear_mode)
            r.seed = seed_from_stable ? crc_stable_run : crc_raw_run;
        r.raw_ones    = raw_total;
        r.saved_ones  = saved_total;
        r.mask_ones   = mask_total;
        r.stable_ones = stable_total;

        // re-arm for the next block
        if (it.last_byte)
        begin
            crc_raw_run    = CRC_START;
            crc_stable_run = CRC_START;
            raw_total      = '0;
            saved_total    = '0;
            mask_total     = '0;
            stable_total   = '0;
        end
        return r;
    endfunction

    task automatic note_mismatch(string field, int unsigned got, int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h",
                     $time, results_seen, field, got, want);
    endtask

    // Sender: holds an item until taken, idles in short bursts
    always @(negedge clk)
    begin
        if (offer_valid && bytes_offered != bytes_accepted)
        begin
            // still waiting for the handshake
        end
        else if (gap_left > 0)
        begin
            offer_valid <= 1'b0;
            gap_left    <= gap_left - 1;
        end
        else if (pending_sram.size() > 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            offer_valid <= 1'b0;
            gap_left    <= $urandom_range(0, 5);
        end
        else if (pending_sram.size() > 0)
        begin
            offer         <= pending_sram[0];
            offer_valid   <= 1'b1;
            bytes_offered <= bytes_offered + 1;
        end
        else
            offer_valid <= 1'b0;
    end

    // Input handshake: predict the result of each accepted item
    always @(posedge clk)
    begin
        if (rst_n && sram_ch.valid && sram_ch.ready)
        begin
            predicted_results.push_back(condition_byte(pending_sram.pop_front()));
            bytes_accepted <= bytes_accepted + 1;
        end
    end

    // Receiver: short random stalls, one long hold-off to back up the block
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            take_result <= 1'b0;
            hold_left   <= hold_left - 1;
        end
        else if (!long_hold_done && bytes_accepted >= LONG_HOLD_AT)
        begin
            take_result    <= 1'b0;
            hold_left      <= LONG_HOLD_CYCLES - 1;
            long_hold_done <= 1'b1;
        end
        else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            take_result <= 1'b0;
            hold_left   <= $urandom_range(0, 5);
        end
        else
            take_result <= 1'b1;
    end

    // Output handshake: compare against the oldest prediction
    always @(posedge clk)
    begin : result_check
        conditioned_t got;
        conditioned_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.new_key_byte    = res_ch.new_key_byte;
            got.new_mask_byte   = res_ch.new_mask_byte;
            got.stable_key_byte = res_ch.stable_key_byte;
            got.block_done      = res_ch.block_done;
            got.seed            = res_ch.seed;
            got.raw_ones        = res_ch.raw_ones;
            got.saved_ones      = res_ch.saved_ones;
            got.mask_ones       = res_ch.mask_ones;
            got.stable_ones     = res_ch.stable_ones;
            if (predicted_results.size() == 0)
                note_mismatch("unexpected item, key byte", 32'(got.new_key_byte), 0);
            else
            begin
                want = predicted_results.pop_front();
                if (got.new_key_byte !== want.new_key_byte)
                    note_mismatch("new_key_byte", 32'(got.new_key_byte),
                                  32'(want.new_key_byte));
                if (got.new_mask_byte !== want.new_mask_byte)
                    note_mismatch("new_mask_byte", 32'(got.new_mask_byte),
                                  32'(want.new_mask_byte));
                if (got.stable_key_byte !== want.stable_key_byte)
                    note_mismatch("stable_key_byte", 32'(got.stable_key_byte),
                                  32'(want.stable_key_byte));
                if (got.block_done !== want.block_done)
                    note_mismatch("block_done", 32'(got.block_done), 32'(want.block_done));
                if (got.seed !== want.seed)
                    note_mismatch("seed", 32'(got.seed), 32'(want.seed));
                if (got.raw_ones !== want.raw_ones)
                    note_mismatch("raw_ones", 32'(got.raw_ones), 32'(want.raw_ones));
                if (got.saved_ones !== want.saved_ones)
                    note_mismatch("saved_ones", 32'(got.saved_ones), 32'(want.saved_ones));
                if (got.mask_ones !== want.mask_ones)
                    note_mismatch("mask_ones", 32'(got.mask_ones), 32'(want.mask_ones));
                if (got.stable_ones !== want.stable_ones)
                    note_mismatch("stable_ones", 32'(got.stable_ones),
                                  32'(want.stable_ones));
            end
            results_seen++;
        end
    end

    // Watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sram_ch.valid && sram_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_byte(logic [BYTE_W-1:0] raw, logic [BYTE_W-1:0] saved,
                             logic [BYTE_W-1:0] msk, logic last);
        puf_byte_t b;
        b.sram_byte       = raw;
        b.saved_key_byte  = saved;
        b.saved_mask_byte = msk;
        b.last_byte       = last;
        pending_sram.push_back(b);
        items_queued++;
    endtask

    // A run of bytes; puf_like gives sparse flips and masks, close ends the block
    task automatic push_block(int len, bit puf_like, bit close);
        logic [BYTE_W-1:0] raw;
        logic [BYTE_W-1:0] flips;
        logic [BYTE_W-1:0] msk;
        for (int n = 0; n < len; n++)
        begin
            raw = BYTE_W'($urandom);
            if (!puf_like)
            begin
                flips = BYTE_W'($urandom);
                msk   = BYTE_W'($urandom);
            end
            else
            begin
                flips = BYTE_W'($urandom & $urandom & $urandom);
                msk   = ($urandom_range(0, 2) == 0) ? '0 :
                        BYTE_W'($urandom & $urandom & $urandom & $urandom);
            end
            push_byte(raw, raw ^ flips, msk, close && (n == len - 1));
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_config(logic clr, logic msk);
        write_reg(CFG_CLEAR_HISTORY, clr);
        write_reg(CFG_MASKED_SEED, msk);
        clear_mode       = clr;
        seed_from_stable = msk;
    endtask

    // Wait until every queued byte is taken and every result has come back
    task automatic drain();
        while (pending_sram.size() != 0 || predicted_results.size() != 0)
            @(negedge clk);
    endtask

    // Stimulus sequence
    initial
    begin
        int phase;
        int nblk;
        int len;
        logic [BYTE_W-1:0] raw;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, field extremes, raw seed
        idle_pct = 20;
        push_byte(8'h00, 8'h00, 8'h00, 1'b1);
        push_byte(8'hFF, 8'hFF, 8'h00, 1'b0);
        push_byte(8'hFF, 8'h00, 8'h00, 1'b0);
        push_byte(8'h00, 8'hFF, 8'hFF, 1'b0);
        push_byte(8'hA5, 8'hA5, 8'h5A, 1'b0);
        push_byte(8'h5A, 8'h3C, 8'h00, 1'b1);
        drain();

        // Clear mode with masked seed: mask byte, stable byte and seed zeroed
        apply_config(1'b1, 1'b1);
        push_byte(8'hFF, 8'hFF, 8'h00, 1'b0);
        push_byte(8'hC3, 8'hC3, 8'h00, 1'b0);
        push_byte(8'h0F, 8'hF0, 8'h00, 1'b1);
        drain();

        // Seed from the stable-byte CRC
        apply_config(1'b0, 1'b1);
        push_byte(8'hFF, 8'hFF, 8'h00, 1'b0);
        push_byte(8'h81, 8'h80, 8'h00, 1'b0);
        push_byte(8'h7E, 8'h7E, 8'h01, 1'b0);
        push_byte(8'hFF, 8'hFF, 8'hFF, 1'b1);
        drain();

        apply_config(1'b1, 1'b0);
        push_byte(8'h12, 8'h34, 8'h00, 1'b0);
        push_byte(8'h55, 8'h55, 8'h00, 1'b1);
        drain();

        // Register changes in the middle of a block
        apply_config(1'b0, 1'b0);
        push_byte(8'hE7, 8'hE7, 8'h00, 1'b0);
        push_byte(8'h18, 8'h18, 8'h00, 1'b0);
        drain();
        apply_config(1'b0, 1'b1);
        push_byte(8'h99, 8'h99, 8'h00, 1'b1);
        drain();
        apply_config(1'b1, 1'b1);
        push_byte(8'h3C, 8'h3C, 8'h00, 1'b0);
        drain();
        apply_config(1'b0, 1'b1);
        push_byte(8'hC3, 8'hC3, 8'h00, 1'b1);
        drain();

        // Long blocks: raw, saved and stable totals saturate, then the mask total;
        // the long receiver hold-off lands in here
        apply_config(1'b0, 1'b1);
        idle_pct = 15;
        for (int n = 0; n < SAT_BLOCK_LEN; n++)
            push_byte(8'hFF, 8'hFF, 8'h00, n == SAT_BLOCK_LEN - 1);
        for (int n = 0; n < SAT_BLOCK_LEN; n++)
        begin
            raw = BYTE_W'($urandom);
            push_byte(raw, ~raw, BYTE_W'($urandom), n == SAT_BLOCK_LEN - 1);
        end
        drain();

        // Random phases, sometimes leaving a block open across a register change
        phase = 0;
        while (items_queued < 1430)
        begin
            case (phase)
                0: apply_config(1'b0, 1'b0);
                1: apply_config(1'b1, 1'b0);
                2: apply_config(1'b0, 1'b1);
                3: apply_config(1'b1, 1'b1);
                default: apply_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 10;
                2: idle_pct = 25;
                default: idle_pct = 40;
            endcase
            nblk = $urandom_range(1, 4);
            for (int b = 0; b < nblk; b++)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) :
                                                    $urandom_range(1, 24);
                push_block(len, $urandom_range(0, 2) != 0, 1'b1);
            end
            if ($urandom_range(0, 3) == 0)
                push_block($urandom_range(1, 10), 1'b1, 1'b0);
            drain();
            phase++;
        end

        // Closing stretch with no idling on either side
        apply_config(1'b0, 1'b1);
        idle_pct = 0;
        for (int b = 0; b < 6; b++)
            push_block($urandom_range(10, 30), b[0], 1'b1);
        drain();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
